FILE: sv/tje_pkg.sv
// Shared constants and state encoding for the tricorn Julia escape iterator.
package tje_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 20;
	localparam int CNT_BITS      = 16;
	localparam int CFG_IDX_BITS  = 3;

	localparam logic [CNT_BITS-1:0] MAX_ITER_RST = 16'd500;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_RE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_IM = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_RE    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROT_IM    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_RE  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_IM  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER  = 3'd6;

	// sequencer states, one-hot
	typedef enum logic [22:0] {
		ST_IDLE     = 23'b1 << 0,
		ST_N_RE     = 23'b1 << 1,
		ST_N_IM     = 23'b1 << 2,
		ST_N_SUM    = 23'b1 << 3,
		ST_N_HUND   = 23'b1 << 4,
		ST_E_CHK    = 23'b1 << 5,
		ST_E_IM     = 23'b1 << 6,
		ST_E_SUM    = 23'b1 << 7,
		ST_E_CMP    = 23'b1 << 8,
		ST_M_RE     = 23'b1 << 9,
		ST_M_IM     = 23'b1 << 10,
		ST_M_DSUM   = 23'b1 << 11,
		ST_M_DCHK   = 23'b1 << 12,
		ST_M_DIV_RE = 23'b1 << 13,
		ST_M_DIV_IM = 23'b1 << 14,
		ST_M_ADD    = 23'b1 << 15,
		ST_M_P1     = 23'b1 << 16,
		ST_M_P2     = 23'b1 << 17,
		ST_M_P3     = 23'b1 << 18,
		ST_M_P4     = 23'b1 << 19,
		ST_M_P5     = 23'b1 << 20,
		ST_M_FIN    = 23'b1 << 21,
		ST_DONE     = 23'b1 << 22
	} state_t;

endpackage

FILE: sv/tricorn_julia_escape_iterator.sv
// Tricorn Julia escape-time iterator: sequencer around one multiplier and one divider.
//
// Input channel (in_valid/in_ready) takes cmd and a start point; output channel
// (out_valid/out_ready) returns one item per input: count and inside_res in escape
// mode, next_re/next_im in map mode. Config channel (cfg_valid/cfg_ready, always
// ready) writes registers by index; unknown indexes are ignored.
// One item is worked at a time; in_ready is high only while the sequencer is idle.
// Each map step makes two bit-serial divisions, skipped for a zero point, plus
// multiplies, sums and checks on the single shared WORD_BITS x WORD_BITS
// multiplier. The sequencer returns to idle, and takes the next item, once the
// result is registered.
// Reset loads the register defaults (A = 1, lambda = 1, T = 2, limit 500) and
// idles the sequencer. A finished item waits in its result register while the
// receiver stalls; the next item may be accepted meanwhile, but its result
// is held back until the output register is free.
module tricorn_julia_escape_iterator #(
	parameter int WORD_BITS = tje_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = tje_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tje_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [WORD_BITS-1:0]              cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic signed [WORD_BITS-1:0]       start_re,
	input  logic signed [WORD_BITS-1:0]       start_im,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tje_pkg::CNT_BITS-1:0]      count,
	output logic                              inside_res,
	output logic signed [WORD_BITS-1:0]       next_re,
	output logic signed [WORD_BITS-1:0]       next_im
);
	import tje_pkg::*;

	localparam int W   = WORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * W;
	localparam int DN  = W + 2 * F;
	localparam int SW  = (PW > DN) ? PW : DN;
	localparam int CW  = $clog2(DN + 1);
	localparam int HW  = PW + 7;

	localparam logic [W-1:0]  MAXV    = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  MINV    = {1'b1, {(W-1){1'b0}}};
	localparam logic [SW-1:0] LIM_POS = SW'(MAXV);
	localparam logic [SW-1:0] LIM_NEG = SW'(MINV);
	localparam logic [W-1:0]  ONE_Q   = W'(1) << F;
	localparam logic [W-1:0]  TWO_Q   = W'(2) << F;
	localparam logic [CW-1:0] DIV_LAST = CW'(DN - 1);

	// saturate sign and magnitude to a word
	function automatic logic [W-1:0] sat_w(input logic neg, input logic [SW-1:0] m);
		logic [W-1:0] r;
		if (neg) begin
			r = (m > LIM_NEG) ? MINV : (-m[W-1:0]);
		end else begin
			r = (m > LIM_POS) ? MAXV : m[W-1:0];
		end
		return r;
	endfunction

	function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		return (s[W] != s[W-1]) ? (s[W] ? MINV : MAXV) : s[W-1:0];
	endfunction

	function automatic logic [W-1:0] ssub(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		return (s[W] != s[W-1]) ? (s[W] ? MINV : MAXV) : s[W-1:0];
	endfunction

	// product truncated toward zero to F fraction bits, saturated
	function automatic logic [W-1:0] fmul(input logic [PW-1:0] p);
		logic          neg;
		logic [PW-1:0] m;
		neg = p[PW-1];
		m = neg ? (-p) : p;
		m = m >> F;
		return sat_w(neg, SW'(m));
	endfunction

	// configuration registers
	logic [W-1:0]          off_re_q, off_im_q, rot_re_q, rot_im_q, scl_re_q, scl_im_q;
	logic [CNT_BITS-1:0]   max_iter_q;

	// sequencer and datapath registers
	state_t                state_q;
	logic                  cmd_q;
	logic [W-1:0]          x_re_q, x_im_q;
	logic [CNT_BITS-1:0]   iter_q;
	logic signed [PW-1:0]  prod_q;
	logic [PW-1:0]         n_q, d_q;
	logic [HW-1:0]         h_q;
	logic [PW:0]           l_q;
	logic [DN-1:0]         num_q;
	logic [DN-2:0]         quo_q;
	logic [PW-1:0]         rem_q;
	logic [CW-1:0]         cnt_q;
	logic [W-1:0]          rr_q, ri_q, sr_q, si_q, t_q, acc_re_q;
	logic [CNT_BITS-1:0]   fin_count_q;
	logic                  fin_inside_q;
	logic [W-1:0]          fin_re_q, fin_im_q;
	logic                  out_valid_q;
	logic [CNT_BITS-1:0]   out_count_q;
	logic                  out_inside_q;
	logic [W-1:0]          out_re_q, out_im_q;

	// shared multiplier operands
	logic signed [W-1:0]   mul_a, mul_b;
	always_comb begin
		mul_a = x_re_q;
		mul_b = x_re_q;
		case (state_q)
			ST_N_RE:  begin mul_a = scl_re_q; mul_b = scl_re_q; end
			ST_N_IM:  begin mul_a = scl_im_q; mul_b = scl_im_q; end
			ST_E_CHK: begin mul_a = x_re_q;   mul_b = scl_re_q; end
			ST_E_IM:  begin mul_a = x_im_q;   mul_b = scl_im_q; end
			ST_M_RE:  begin mul_a = x_re_q;   mul_b = x_re_q;   end
			ST_M_IM:  begin mul_a = x_im_q;   mul_b = x_im_q;   end
			ST_M_P1:  begin mul_a = rot_re_q; mul_b = sr_q;     end
			ST_M_P2:  begin mul_a = rot_im_q; mul_b = si_q;     end
			ST_M_P3:  begin mul_a = rot_im_q; mul_b = sr_q;     end
			ST_M_P4:  begin mul_a = rot_re_q; mul_b = si_q;     end
			default:  begin mul_a = x_re_q;   mul_b = x_re_q;   end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// restoring divider step
	logic [PW:0]   div_rs;
	logic          div_ge;
	logic [PW:0]   div_rem;
	logic [DN-1:0] div_quo;
	always_comb begin
		div_rs  = {rem_q, num_q[DN-1]};
		div_ge  = (div_rs >= {1'b0, d_q});
		div_rem = div_ge ? (div_rs - {1'b0, d_q}) : div_rs;
		div_quo = {quo_q, div_ge};
	end

	// magnitudes of the current point
	logic [W-1:0] mag_re, mag_im;
	assign mag_re = x_re_q[W-1] ? (-x_re_q) : x_re_q;
	assign mag_im = x_im_q[W-1] ? (-x_im_q) : x_im_q;

	// escape test and zero point
	logic                  esc_hit, x_zero;
	logic [CNT_BITS:0]     iter_inc;
	assign esc_hit  = $signed({{(HW-PW){l_q[PW]}}, l_q}) >= $signed({1'b0, h_q});
	assign x_zero   = (x_re_q == '0) && (x_im_q == '0);
	assign iter_inc = {1'b0, iter_q} + 1'b1;

	// map step result
	logic [W-1:0] y_re, y_im;
	assign y_re = sadd(acc_re_q, off_re_q);
	assign y_im = sadd(t_q, off_im_q);

	// configuration writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_re_q   <= ONE_Q;
			off_im_q   <= '0;
			rot_re_q   <= ONE_Q;
			rot_im_q   <= '0;
			scl_re_q   <= TWO_Q;
			scl_im_q   <= '0;
			max_iter_q <= MAX_ITER_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OFFSET_RE: off_re_q   <= cfg_data;
				CFG_OFFSET_IM: off_im_q   <= cfg_data;
				CFG_ROT_RE:    rot_re_q   <= cfg_data;
				CFG_ROT_IM:    rot_im_q   <= cfg_data;
				CFG_SCALE_RE:  scl_re_q   <= cfg_data;
				CFG_SCALE_IM:  scl_im_q   <= cfg_data;
				CFG_MAX_ITER:  max_iter_q <= cfg_data[CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					state_q <= cmd ? ST_M_RE : ST_N_RE;
				end
				ST_N_RE:   state_q <= ST_N_IM;
				ST_N_IM:   state_q <= ST_N_SUM;
				ST_N_SUM:  state_q <= ST_N_HUND;
				ST_N_HUND: state_q <= ST_E_CHK;
				ST_E_CHK:  state_q <= (iter_q >= max_iter_q) ? ST_DONE : ST_E_IM;
				ST_E_IM:   state_q <= ST_E_SUM;
				ST_E_SUM:  state_q <= ST_E_CMP;
				ST_E_CMP:  state_q <= (esc_hit || x_zero) ? ST_DONE : ST_M_RE;
				ST_M_RE:   state_q <= ST_M_IM;
				ST_M_IM:   state_q <= ST_M_DSUM;
				ST_M_DSUM: state_q <= ST_M_DCHK;
				ST_M_DCHK: state_q <= (d_q == '0) ? ST_M_ADD : ST_M_DIV_RE;
				ST_M_DIV_RE: if (cnt_q == DIV_LAST) state_q <= ST_M_DIV_IM;
				ST_M_DIV_IM: if (cnt_q == DIV_LAST) state_q <= ST_M_ADD;
				ST_M_ADD:  state_q <= ST_M_P1;
				ST_M_P1:   state_q <= ST_M_P2;
				ST_M_P2:   state_q <= ST_M_P3;
				ST_M_P3:   state_q <= ST_M_P4;
				ST_M_P4:   state_q <= ST_M_P5;
				ST_M_P5:   state_q <= ST_M_FIN;
				ST_M_FIN:  state_q <= cmd_q ? ST_DONE : ST_E_CHK;
				ST_DONE: if (!out_valid_q || out_ready) begin
					state_q <= ST_IDLE;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q  <= cmd;
				x_re_q <= start_re;
				x_im_q <= start_im;
				iter_q <= '0;
			end
			ST_N_IM:   n_q <= prod_q;
			ST_N_SUM:  n_q <= n_q + prod_q;
			ST_N_HUND: h_q <= (HW'(n_q) << 6) + (HW'(n_q) << 5) + (HW'(n_q) << 2);
			ST_E_CHK: begin
				fin_count_q  <= '0;
				fin_inside_q <= 1'b1;
				fin_re_q     <= '0;
				fin_im_q     <= '0;
			end
			ST_E_IM:   l_q <= {prod_q[PW-1], prod_q};
			ST_E_SUM:  l_q <= l_q + {prod_q[PW-1], prod_q};
			ST_E_CMP: begin
				if (esc_hit) begin
					fin_count_q  <= iter_q;
					fin_inside_q <= 1'b0;
				end else if (iter_inc >= {1'b0, max_iter_q}) begin
					fin_count_q  <= '0;
					fin_inside_q <= 1'b1;
				end else begin
					fin_count_q  <= iter_inc[CNT_BITS-1:0];
					fin_inside_q <= 1'b0;
				end
			end
			ST_M_IM:   d_q <= prod_q;
			ST_M_DSUM: d_q <= d_q + prod_q;
			ST_M_DCHK: begin
				rr_q  <= '0;
				ri_q  <= '0;
				num_q <= {mag_re, {(2*F){1'b0}}};
				quo_q <= '0;
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_M_DIV_RE: begin
				if (cnt_q == DIV_LAST) begin
					rr_q  <= sat_w(x_re_q[W-1], SW'(div_quo));
					num_q <= {mag_im, {(2*F){1'b0}}};
					quo_q <= '0;
					rem_q <= '0;
					cnt_q <= '0;
				end else begin
					num_q <= num_q << 1;
					quo_q <= div_quo[DN-2:0];
					rem_q <= div_rem[PW-1:0];
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_M_DIV_IM: begin
				if (cnt_q == DIV_LAST) begin
					ri_q <= sat_w(!x_im_q[W-1] && (x_im_q != '0), SW'(div_quo));
				end else begin
					num_q <= num_q << 1;
					quo_q <= div_quo[DN-2:0];
					rem_q <= div_rem[PW-1:0];
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_M_ADD: begin
				sr_q <= sadd(x_re_q, rr_q);
				si_q <= sadd(x_im_q, ri_q);
			end
			ST_M_P2:   t_q <= fmul(prod_q);
			ST_M_P3:   acc_re_q <= sadd(t_q, fmul(prod_q));
			ST_M_P4:   t_q <= fmul(prod_q);
			ST_M_P5:   t_q <= ssub(t_q, fmul(prod_q));
			ST_M_FIN: begin
				if (cmd_q) begin
					fin_count_q  <= '0;
					fin_inside_q <= 1'b0;
					fin_re_q     <= y_re;
					fin_im_q     <= y_im;
				end else begin
					x_re_q <= y_re;
					x_im_q <= y_im;
					iter_q <= iter_inc[CNT_BITS-1:0];
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_count_q  <= fin_count_q;
			out_inside_q <= fin_inside_q;
			out_re_q     <= fin_re_q;
			out_im_q     <= fin_im_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign count      = out_count_q;
	assign inside_res = out_inside_q;
	assign next_re    = out_re_q;
	assign next_im    = out_im_q;

endmodule

FILE: bench/tricorn_julia_escape_iterator_test.sv
// Self-checking testbench for the tricorn Julia escape iterator: escape counts and map steps.
`timescale 1ns / 100ps

module tricorn_julia_escape_iterator_test;
	import tje_pkg::*;

	localparam int W  = WORD_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam logic signed [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE  = 1 <<< FB;
	localparam longint CYCLE_LIMIT = 64'd80_000_000;
	// index that maps to no register
	localparam logic [CFG_IDX_BITS-1:0] CFG_NONE = 3'd7;

	typedef enum logic {OP_ESCAPE = 1'b0, OP_MAP = 1'b1} op_t;

	typedef struct packed {
		logic            is_cfg;
		logic [CFG_IDX_BITS-1:0] idx;
		logic [W-1:0]    data;
		op_t             op;
		logic signed [W-1:0] zr;
		logic signed [W-1:0] zi;
	} pend_t;

	typedef struct packed {
		logic [CNT_BITS-1:0] cnt;
		logic                ins;
		logic signed [W-1:0] nr;
		logic signed [W-1:0] ni;
	} orbit_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [W-1:0] cfg_data;
	logic in_valid, in_ready, cmd;
	logic signed [W-1:0] start_re, start_im;
	logic out_valid, out_ready;
	logic [CNT_BITS-1:0] count;
	logic inside_res;
	logic signed [W-1:0] next_re, next_im;

	tricorn_julia_escape_iterator dut (.*);

	// predictor copy of the registers
	logic signed [W-1:0] p_off_re = ONE, p_off_im = '0, p_rot_re = ONE, p_rot_im = '0;
	logic signed [W-1:0] p_sc_re = 2 * ONE, p_sc_im = '0;
	logic [CNT_BITS-1:0] p_limit = MAX_ITER_RST;

	pend_t  pending[$];
	orbit_t expected_orbits[$];
	int     errors = 0;
	bit     quiet_tail;
	longint cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// saturate a signed wide value to the word
	function automatic logic signed [W-1:0] clip(input logic signed [191:0] v);
		if (v > $signed({{(192-W){1'b0}}, QMAX})) return QMAX;
		if (v < $signed({{(192-W){1'b1}}, QMIN})) return QMIN;
		return v[W-1:0];
	endfunction

	// product truncated toward zero to FB fraction bits
	function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [191:0] p;
		logic [191:0] m;
		p = $signed(a) * $signed(b);
		m = (p < 0) ? -p : p;
		m = m >> FB;
		return clip((p < 0) ? -$signed(m) : $signed(m));
	endfunction

	function automatic logic signed [W-1:0] qadd(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		return clip($signed({{(192-W){a[W-1]}}, a}) + $signed({{(192-W){b[W-1]}}, b}));
	endfunction

	function automatic logic signed [W-1:0] qsub(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		return clip($signed({{(192-W){a[W-1]}}, a}) - $signed({{(192-W){b[W-1]}}, b}));
	endfunction

	// one map step: lambda * conj(x + 1/x) + A
	task automatic tricorn_step(input logic signed [W-1:0] xr, input logic signed [W-1:0] xi,
			output logic signed [W-1:0] yr, output logic signed [W-1:0] yi);
		logic signed [191:0] d, q;
		logic signed [W-1:0] rr, ri, sr, si;
		d = $signed(xr) * $signed(xr) + $signed(xi) * $signed(xi);
		rr = '0;
		ri = '0;
		if (d != 0) begin
			q = ($signed({{(192-W){xr[W-1]}}, xr}) <<< (2*FB)) / d;
			rr = clip(q);
			q = -(($signed({{(192-W){xi[W-1]}}, xi}) <<< (2*FB)) / d);
			ri = clip(q);
		end
		sr = qadd(xr, rr);
		si = qadd(xi, ri);
		yr = qadd(qadd(qmul(p_rot_re, sr), qmul(p_rot_im, si)), p_off_re);
		yi = qadd(qsub(qmul(p_rot_im, sr), qmul(p_rot_re, si)), p_off_im);
	endtask

	// exact test Re(x conj T) >= 100 |T|^2
	function automatic bit has_escaped(input logic signed [W-1:0] xr,
			input logic signed [W-1:0] xi);
		logic signed [191:0] l, n;
		l = $signed(xr) * $signed(p_sc_re) + $signed(xi) * $signed(p_sc_im);
		n = $signed(p_sc_re) * $signed(p_sc_re) + $signed(p_sc_im) * $signed(p_sc_im);
		return l >= n * 100;
	endfunction

	task automatic predict_orbit(input op_t op, input logic signed [W-1:0] zr,
			input logic signed [W-1:0] zi);
		orbit_t o;
		logic signed [W-1:0] xr, xi, yr, yi;
		int i;
		o = '0;
		xr = zr;
		xi = zi;
		if (op == OP_MAP) begin
			tricorn_step(xr, xi, yr, yi);
			o.nr = yr;
			o.ni = yi;
		end else begin
			for (i = 0; i < p_limit; i++) begin
				if (has_escaped(xr, xi)) break;
				if (xr == 0 && xi == 0) begin
					i++;
					break;
				end
				tricorn_step(xr, xi, yr, yi);
				xr = yr;
				xi = yi;
			end
			if (i >= p_limit) o.ins = 1'b1;
			else o.cnt = i[CNT_BITS-1:0];
		end
		expected_orbits.push_back(o);
	endtask

	task automatic apply_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [W-1:0] v);
		case (idx)
			CFG_OFFSET_RE: p_off_re = v;
			CFG_OFFSET_IM: p_off_im = v;
			CFG_ROT_RE:    p_rot_re = v;
			CFG_ROT_IM:    p_rot_im = v;
			CFG_SCALE_RE:  p_sc_re = v;
			CFG_SCALE_IM:  p_sc_im = v;
			CFG_MAX_ITER:  p_limit = v[CNT_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic q_point(input op_t op, input logic signed [W-1:0] zr,
			input logic signed [W-1:0] zi);
		pend_t p;
		p = '0;
		p.op = op;
		p.zr = zr;
		p.zi = zi;
		pending.push_back(p);
	endtask

	task automatic q_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [W-1:0] v);
		pend_t p;
		p = '0;
		p.is_cfg = 1'b1;
		p.idx = idx;
		p.data = v;
		pending.push_back(p);
	endtask

	// wait for the block to drain before a register write
	task automatic drain();
		while (pending.size() != 0 || expected_orbits.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic signed [W-1:0] rnd_word();
		logic signed [W-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 3))
			0: return v;
			1: return $signed(v) >>> ($urandom_range(6, 12));
			2: return $signed(v) >>> 9;
			default: return $signed(v) >>> 11;
		endcase
	endfunction

	// handshake flags seen at the rising edge
	bit in_taken, cfg_taken;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken  <= 1'b0;
			cfg_taken <= 1'b0;
		end else begin
			in_taken  <= in_valid && in_ready;
			cfg_taken <= cfg_valid && cfg_ready;
		end
	end

	// driver: next pending item or register write at the falling edge
	pend_t cur;
	bit    busy;
	bit    nxt_in, nxt_cfg;
	int    gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
			cmd       <= 1'b0;
			start_re  <= '0;
			start_im  <= '0;
			cfg_index <= '0;
			cfg_data  <= '0;
			busy = 1'b0;
			gap  = 0;
		end else begin
			nxt_in  = in_valid;
			nxt_cfg = cfg_valid;
			if (busy && (cur.is_cfg ? cfg_taken : in_taken)) begin
				busy    = 1'b0;
				nxt_in  = 1'b0;
				nxt_cfg = 1'b0;
			end
			if (!busy && gap > 0 && !quiet_tail) begin
				gap--;
			end else if (!busy && pending.size() != 0) begin
				cur = pending.pop_front();
				busy = 1'b1;
				if (cur.is_cfg) begin
					apply_reg(cur.idx, cur.data);
					cfg_index <= cur.idx;
					cfg_data <= cur.data;
					nxt_cfg = 1'b1;
				end else begin
					predict_orbit(cur.op, cur.zr, cur.zi);
					cmd <= cur.op;
					start_re <= cur.zr;
					start_im <= cur.zi;
					nxt_in = 1'b1;
				end
				// idle burst after this item
				gap = (!quiet_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
			end
			in_valid  <= nxt_in;
			cfg_valid <= nxt_cfg;
		end
	end

	// receiver stall bursts
	int stall;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall = 0;
		end else if (quiet_tail) begin
			out_ready <= 1'b1;
		end else if (stall > 0) begin
			stall--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall = $urandom_range(0, 9);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: compare each result item against the oldest prediction
	always @(posedge clk) begin
		orbit_t e;
		cycles++;
		if (arst_n && out_valid && out_ready) begin
			if (expected_orbits.size() == 0) begin
				$error("unexpected result item count=%0d", count);
				errors++;
			end else begin
				e = expected_orbits.pop_front();
				if (count !== e.cnt) begin
					$error("count exp %0d got %0d", e.cnt, count); errors++;
				end
				if (inside_res !== e.ins) begin
					$error("inside_res exp %0d got %0d", e.ins, inside_res); errors++;
				end
				if (next_re !== e.nr) begin
					$error("next_re exp %0d got %0d", e.nr, next_re); errors++;
				end
				if (next_im !== e.ni) begin
					$error("next_im exp %0d got %0d", e.ni, next_im); errors++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// register settings: each row is A, lambda, T, limit
	task automatic load_regs(input logic signed [W-1:0] ar, input logic signed [W-1:0] ai,
			input logic signed [W-1:0] lr, input logic signed [W-1:0] li,
			input logic signed [W-1:0] tr, input logic signed [W-1:0] ti,
			input logic [CNT_BITS-1:0] lim);
		drain();
		q_reg(CFG_OFFSET_RE, ar);
		q_reg(CFG_OFFSET_IM, ai);
		q_reg(CFG_ROT_RE, lr);
		q_reg(CFG_ROT_IM, li);
		q_reg(CFG_SCALE_RE, tr);
		q_reg(CFG_SCALE_IM, ti);
		q_reg(CFG_MAX_ITER, W'(lim));
		drain();
	endtask

	task automatic random_points(input int n);
		int k;
		for (k = 0; k < n; k++)
			q_point($urandom_range(0, 2) == 0 ? OP_ESCAPE : OP_MAP, rnd_word(), rnd_word());
	endtask

	initial begin
		quiet_tail = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset registers, extremes, zero point, both ops
		q_point(OP_MAP, '0, '0);
		q_point(OP_ESCAPE, '0, '0);
		q_point(OP_ESCAPE, 300 * ONE, '0);
		q_point(OP_ESCAPE, QMIN, QMIN);
		q_point(OP_MAP, QMAX, QMIN);
		q_point(OP_MAP, QMIN, QMAX);
		q_point(OP_MAP, 1, -1);
		q_point(OP_ESCAPE, ONE / 2, ONE / 3);
		q_point(OP_MAP, -ONE, ONE);
		// zero limit, zero reference, extreme registers, unknown index
		load_regs(QMIN, QMAX, QMAX, QMIN, 0, 0, 16'd0);
		q_reg(CFG_NONE, 32'hFFFF_FFFF);
		q_point(OP_ESCAPE, ONE, ONE);
		q_point(OP_MAP, ONE, -ONE);
		q_point(OP_MAP, QMAX, QMAX);
		load_regs(ONE, 0, ONE, 0, 0, 0, 16'd20);
		q_point(OP_ESCAPE, -ONE, ONE);
		load_regs(QMAX, QMIN, QMIN, QMAX, QMIN, QMAX, 16'hFFFF);
		q_point(OP_ESCAPE, QMAX, QMIN);
		q_point(OP_MAP, ONE, ONE);
		load_regs(ONE / 4, -ONE / 8, 741455, 741455, ONE / 10, ONE / 10, 16'd1);
		q_point(OP_ESCAPE, '0, '0);
		q_point(OP_ESCAPE, ONE, ONE);
		q_point(OP_MAP, '0, '0);

		// random phases with moderate limits to keep the run short
		load_regs(ONE, 0, ONE, 0, 2 * ONE, 0, 16'd40);
		random_points(30);
		load_regs(rnd_word(), rnd_word(), 1002045, -313022, ONE / 2, ONE / 5, 16'd60);
		random_points(30);
		load_regs(rnd_word(), rnd_word(), $urandom, $urandom, rnd_word(), rnd_word(),
			16'($urandom_range(0, 30)));
		random_points(20);
		drain();
		quiet_tail = 1;
		load_regs(-ONE / 3, ONE / 7, -ONE, 0, ONE, -ONE, 16'd25);
		random_points(20);

		drain();
		repeat (300) @(posedge clk);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
sv/tje_pkg.sv
sv/tricorn_julia_escape_iterator.sv
bench/tricorn_julia_escape_iterator_test.sv
